// File: design/kpaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpaf_pkg
// Types, constants and state codes for the pitch angle fusion core.
// ----------------------------------------------------------------------------
package kpaf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 2'd3;

  localparam logic [24:0] RST_SAMPLE_PERIOD = 25'd83886;
  localparam logic [30:0] RST_ANGLE_NOISE   = 31'd16777;
  localparam logic [30:0] RST_BIAS_NOISE    = 31'd50332;
  localparam logic [30:0] RST_MEAS_NOISE    = 31'd6710886;

  // Arithmetic unit operations
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // Sequencer states; ST_S0 to ST_S25 run one arithmetic operation each
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S0,  ST_S1,  ST_S2,  ST_S3,  ST_S4,  ST_S5,  ST_S6,  ST_S7,
    ST_S8,  ST_S9,  ST_S10, ST_S11, ST_S12, ST_S13, ST_S14, ST_S15,
    ST_S16, ST_S17, ST_S18, ST_S19, ST_S20, ST_S21, ST_S22, ST_S23,
    ST_S24, ST_S25, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

endpackage

// File: design/kpaf_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpaf_alu
// Saturating fixed-point add, subtract, bit-serial multiply and restoring
// divide. One bit of the multiplier or quotient is handled per cycle.
// ----------------------------------------------------------------------------
module kpaf_alu #(
  parameter int DATA_WIDTH = kpaf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kpaf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kpaf_pkg::alu_ctl_t           ctl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] y
);

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;        // magnitude product width
  localparam int QW  = W + FRAC_BITS; // dividend / quotient width
  localparam int CW  = $clog2(QW + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  kpaf_pkg::op_t op_r, op_nxt;
  logic          neg_r, neg_nxt;
  logic [PW-1:0] acc_r, acc_nxt;   // product accumulator, unused for div
  logic [W-1:0]  mcand_r, mcand_nxt;
  logic [QW-1:0] sh_r, sh_nxt;     // multiplier bits or dividend/quotient
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dm_r, dm_nxt;
  logic signed [W-1:0] y_r, y_nxt;

  logic [W-1:0]  mag_a, mag_b;
  logic signed [W:0] sum;
  logic [W:0]    rem_sh;
  logic [PW-1:0] pshift;
  logic [W:0]    lim;
  logic [W:0]    rmag;
  logic          ovf;

  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;
  assign rem_sh = {rem_r[W-1:0], sh_r[QW-1]};
  assign pshift = acc_r >> FRAC_BITS;
  assign lim = neg_r ? {1'b0, 1'b1, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};

  always_comb begin
    rmag = '0;
    ovf  = 1'b0;
    if (op_r == kpaf_pkg::OP_MUL) begin
      ovf  = (pshift[PW-1:W] != '0) || ({1'b0, pshift[W-1:0]} > lim);
      rmag = {1'b0, pshift[W-1:0]};
    end else begin
      ovf  = (sh_r[QW-1:W] != '0) || ({1'b0, sh_r[W-1:0]} > lim);
      rmag = {1'b0, sh_r[W-1:0]};
    end
    if (ovf) rmag = lim;
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    dm_nxt    = dm_r;
    y_nxt     = y_r;
    sum       = '0;
    if (ctl.start) begin
      op_nxt  = ctl.op;
      neg_nxt = a[W-1] ^ b[W-1];
      case (ctl.op)
        kpaf_pkg::OP_ADD, kpaf_pkg::OP_SUB: begin
          sum = (ctl.op == kpaf_pkg::OP_ADD) ? ({a[W-1], a} + {b[W-1], b})
                                             : ({a[W-1], a} - {b[W-1], b});
          // top two bits differ only on overflow
          if (sum[W] != sum[W-1]) y_nxt = sum[W] ? WMIN : WMAX;
          else y_nxt = sum[W-1:0];
          done_nxt = 1'b1;
        end
        kpaf_pkg::OP_MUL: begin
          busy_nxt  = 1'b1;
          acc_nxt   = '0;
          mcand_nxt = mag_a;
          sh_nxt    = {{(QW-W){1'b0}}, mag_b};
          cnt_nxt   = CW'(W);
        end
        kpaf_pkg::OP_DIV: begin
          if (mag_b == '0) begin
            y_nxt    = '0;
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            sh_nxt   = {mag_a, {FRAC_BITS{1'b0}}};
            rem_nxt  = '0;
            dm_nxt   = mag_b;
            cnt_nxt  = CW'(QW);
          end
        end
        default: ;
      endcase
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        if (op_r == kpaf_pkg::OP_MUL) begin
          // shift-and-add, multiplier LSB first, top bit of product built last
          if (sh_r[0]) acc_nxt = acc_r + {mcand_r, {W{1'b0}}};
          acc_nxt = acc_nxt >> 1;
          sh_nxt  = sh_r >> 1;
        end else begin
          if (rem_sh >= {1'b0, dm_r}) begin
            rem_nxt = rem_sh - {1'b0, dm_r};
            sh_nxt  = {sh_r[QW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            sh_nxt  = {sh_r[QW-2:0], 1'b0};
          end
        end
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        y_nxt    = neg_r ? W'(~rmag + 1'b1) : rmag[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= kpaf_pkg::OP_ADD;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    sh_r    <= sh_nxt;
    rem_r   <= rem_nxt;
    dm_r    <= dm_nxt;
    y_r     <= y_nxt;
  end

  assign done = done_r;
  assign y    = y_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !ctl.start) else $error("alu started while busy");
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("alu done held");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0) |=> (done_r && !busy_r))
    else $error("alu did not finish");

endmodule

// File: design/kalman_pitch_angle_fusion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_pitch_angle_fusion_core
// Two-state angle/gyro-bias Kalman filter, one shared serial arithmetic unit.
// ----------------------------------------------------------------------------
// One sample is taken at a time and needs 26 arithmetic steps on one shared
// unit: add/subtract are done in a single step, multiply and divide run
// bit-serially. The steps are 11 products, 2 quotients and 13 add/sub, after
// which the result is posted on out_tvalid. The next sample is taken only
// after the result has been transferred out.
// ----------------------------------------------------------------------------
module kalman_pitch_angle_fusion_core #(
  parameter int DATA_WIDTH = kpaf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = kpaf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kpaf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpaf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [26:0] accel_angle, [57:27] gyro_rate, [63:58] zero
  input  logic [63:0]                       in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] filtered_angle, [63:32] corrected_rate
  output logic [63:0]                       out_tdata
);

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< FRAC_BITS);

  typedef logic signed [W-1:0] word_t;

  logic [24:0] dt_r;
  logic [30:0] qa_r, qb_r, rm_r;

  word_t ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  word_t meas_r, gyro_r;
  word_t t0_r, t1_r, ap_r, a00_r, a01_r, a10_r, a11_r, err_r, s_r, k0_r, k1_r;
  word_t fa_r, cr_r;
  logic  ov_r;

  kpaf_pkg::state_t st_r, st_nxt;
  logic started_r, started_nxt;

  kpaf_pkg::alu_ctl_t ctl;
  kpaf_pkg::op_t op_sel;
  word_t opa, opb, y;
  logic  done;

  word_t dtw, qaw, qbw, rmw;

  function automatic word_t clampu(input logic [30:0] v);
    logic [63:0] e;
    e = 64'(v);
    if (e > 64'({1'b0, {(W-1){1'b1}}})) return {1'b0, {(W-1){1'b1}}};
    return W'(e);
  endfunction

  assign dtw = clampu(31'(dt_r));
  assign qaw = clampu(qa_r);
  assign qbw = clampu(qb_r);
  assign rmw = clampu(rm_r);

  function automatic word_t clampin(input logic signed [30:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'(signed'({1'b0, {(W-1){1'b1}}}))) return {1'b0, {(W-1){1'b1}}};
    if (e < -64'(signed'({1'b0, {(W-1){1'b1}}})) - 1) return {1'b1, {(W-1){1'b0}}};
    return W'(e);
  endfunction

  function automatic logic [31:0] sat32(input word_t v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'sd2147483647) return 32'h7fffffff;
    if (e < -64'sd2147483648) return 32'h80000000;
    return e[31:0];
  endfunction

  function automatic word_t sat_sub(input word_t x, input word_t v);
    logic [W:0] d;
    d = {x[W-1], x} - {v[W-1], v};
    if (d[W] != d[W-1]) return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    return d[W-1:0];
  endfunction

  kpaf_alu #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .a(opa), .b(opb), .done(done), .y(y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= kpaf_pkg::RST_SAMPLE_PERIOD;
      qa_r <= kpaf_pkg::RST_ANGLE_NOISE;
      qb_r <= kpaf_pkg::RST_BIAS_NOISE;
      rm_r <= kpaf_pkg::RST_MEAS_NOISE;
    end else if (cfg_we) begin
      case (cfg_index)
        kpaf_pkg::REG_SAMPLE_PERIOD: dt_r <= cfg_data[24:0];
        kpaf_pkg::REG_ANGLE_NOISE:   qa_r <= cfg_data;
        kpaf_pkg::REG_BIAS_NOISE:    qb_r <= cfg_data;
        kpaf_pkg::REG_MEAS_NOISE:    rm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = (st_r == kpaf_pkg::ST_IDLE) && !ov_r;

  // step table: operation and operands for each state
  always_comb begin
    op_sel = kpaf_pkg::OP_ADD;
    opa = '0;
    opb = '0;
    case (st_r)
      kpaf_pkg::ST_S0:  begin op_sel = kpaf_pkg::OP_SUB; opa = gyro_r; opb = bias_r; end
      kpaf_pkg::ST_S1:  begin op_sel = kpaf_pkg::OP_MUL; opa = t0_r;   opb = dtw;    end
      kpaf_pkg::ST_S2:  begin op_sel = kpaf_pkg::OP_ADD; opa = ang_r;  opb = t0_r;   end
      kpaf_pkg::ST_S3:  begin op_sel = kpaf_pkg::OP_MUL; opa = dtw;    opb = p10_r;  end
      kpaf_pkg::ST_S4:  begin op_sel = kpaf_pkg::OP_SUB; opa = p00_r;  opb = t0_r;   end
      kpaf_pkg::ST_S5:  begin op_sel = kpaf_pkg::OP_MUL; opa = dtw;    opb = p11_r;  end
      kpaf_pkg::ST_S6:  begin op_sel = kpaf_pkg::OP_SUB; opa = p01_r;  opb = t1_r;   end
      kpaf_pkg::ST_S7:  begin op_sel = kpaf_pkg::OP_MUL; opa = a01_r;  opb = dtw;    end
      kpaf_pkg::ST_S8:  begin op_sel = kpaf_pkg::OP_SUB; opa = a00_r;  opb = t1_r;   end
      kpaf_pkg::ST_S9:  begin op_sel = kpaf_pkg::OP_ADD; opa = a00_r;  opb = qaw;    end
      kpaf_pkg::ST_S10: begin op_sel = kpaf_pkg::OP_MUL; opa = p11_r;  opb = dtw;    end
      kpaf_pkg::ST_S11: begin op_sel = kpaf_pkg::OP_SUB; opa = p10_r;  opb = t1_r;   end
      kpaf_pkg::ST_S12: begin op_sel = kpaf_pkg::OP_ADD; opa = p11_r;  opb = qbw;    end
      kpaf_pkg::ST_S13: begin op_sel = kpaf_pkg::OP_SUB; opa = meas_r; opb = ap_r;   end
      kpaf_pkg::ST_S14: begin op_sel = kpaf_pkg::OP_ADD; opa = a00_r;  opb = rmw;    end
      kpaf_pkg::ST_S15: begin op_sel = kpaf_pkg::OP_DIV; opa = a00_r;  opb = s_r;    end
      kpaf_pkg::ST_S16: begin op_sel = kpaf_pkg::OP_DIV; opa = a10_r;  opb = s_r;    end
      kpaf_pkg::ST_S17: begin op_sel = kpaf_pkg::OP_MUL; opa = k0_r;   opb = err_r;  end
      kpaf_pkg::ST_S18: begin op_sel = kpaf_pkg::OP_ADD; opa = ap_r;   opb = t0_r;   end
      kpaf_pkg::ST_S19: begin op_sel = kpaf_pkg::OP_MUL; opa = k1_r;   opb = err_r;  end
      kpaf_pkg::ST_S20: begin op_sel = kpaf_pkg::OP_ADD; opa = bias_r; opb = t0_r;   end
      kpaf_pkg::ST_S21: begin op_sel = kpaf_pkg::OP_SUB; opa = gyro_r; opb = bias_r; end
      kpaf_pkg::ST_S22: begin op_sel = kpaf_pkg::OP_MUL; opa = k0_r;   opb = a00_r;  end
      kpaf_pkg::ST_S23: begin op_sel = kpaf_pkg::OP_MUL; opa = k0_r;   opb = a01_r;  end
      kpaf_pkg::ST_S24: begin op_sel = kpaf_pkg::OP_MUL; opa = k1_r;   opb = a00_r;  end
      kpaf_pkg::ST_S25: begin op_sel = kpaf_pkg::OP_MUL; opa = k1_r;   opb = a01_r;  end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt      = st_r;
    started_nxt = started_r;
    ctl.start   = 1'b0;
    ctl.op      = op_sel;
    case (st_r)
      kpaf_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) st_nxt = kpaf_pkg::ST_S0;
      end
      kpaf_pkg::ST_OUT: st_nxt = kpaf_pkg::ST_IDLE;
      default: begin
        if (!started_r) begin
          ctl.start   = 1'b1;
          started_nxt = 1'b1;
        end else if (done) begin
          started_nxt = 1'b0;
          st_nxt      = kpaf_pkg::state_t'(st_r + 1'b1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= kpaf_pkg::ST_IDLE;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
      ang_r     <= '0;
      bias_r    <= '0;
      p00_r     <= ONE;
      p01_r     <= '0;
      p10_r     <= '0;
      p11_r     <= ONE;
    end else begin
      st_r      <= st_nxt;
      started_r <= started_nxt;
      if (st_r == kpaf_pkg::ST_OUT) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (started_r && done) begin
        case (st_r)
          kpaf_pkg::ST_S0, kpaf_pkg::ST_S1, kpaf_pkg::ST_S3,
          kpaf_pkg::ST_S17, kpaf_pkg::ST_S19: t0_r <= y;
          kpaf_pkg::ST_S2:  ap_r  <= y;
          kpaf_pkg::ST_S4:  a00_r <= y;
          kpaf_pkg::ST_S5, kpaf_pkg::ST_S7, kpaf_pkg::ST_S10: t1_r <= y;
          kpaf_pkg::ST_S6:  a01_r <= y;
          kpaf_pkg::ST_S8, kpaf_pkg::ST_S9: a00_r <= y;
          kpaf_pkg::ST_S11: a10_r <= y;
          kpaf_pkg::ST_S12: a11_r <= y;
          kpaf_pkg::ST_S13: err_r <= y;
          kpaf_pkg::ST_S14: s_r   <= y;
          kpaf_pkg::ST_S15: k0_r  <= (s_r == '0) ? '0 : y;
          kpaf_pkg::ST_S16: k1_r  <= (s_r == '0) ? '0 : y;
          kpaf_pkg::ST_S18: ang_r <= y;
          kpaf_pkg::ST_S20: bias_r <= y;
          kpaf_pkg::ST_S21: cr_r  <= y;
          kpaf_pkg::ST_S22: p00_r <= sat_sub(a00_r, y);
          kpaf_pkg::ST_S23: p01_r <= sat_sub(a01_r, y);
          kpaf_pkg::ST_S24: p10_r <= sat_sub(a10_r, y);
          kpaf_pkg::ST_S25: p11_r <= sat_sub(a11_r, y);
          default: ;
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      meas_r <= clampin(31'(signed'(in_tdata[26:0])));
      gyro_r <= clampin(signed'(in_tdata[57:27]));
    end
    if (st_r == kpaf_pkg::ST_OUT) fa_r <= ang_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {sat32(cr_r), sat32(fa_r)};

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != kpaf_pkg::ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == kpaf_pkg::ST_OUT) |=> (st_r == kpaf_pkg::ST_IDLE && ov_r))
    else $error("result not posted");

endmodule
